/* sv/trw_pkg.sv */
// Shared constants and types for the Reno congestion window update block.
// No dependencies; every other file of the block imports this package.
package trw_pkg;

	localparam int WINDOW_BITS_DEF = 32;

	localparam int OP_BITS    = 2;
	localparam int SEG_BITS   = 16;
	localparam int ACKED_BITS = 16;
	localparam int LOAD_BITS  = 32;
	localparam int OUT_BITS   = 32;
	localparam int CNT_BITS   = 32;

	localparam logic [SEG_BITS-1:0] SEG_RESET = 16'd536;
	localparam int WINDOW_RESET = 5360;

	typedef enum logic [OP_BITS-1:0] {
		OP_ACK  = 2'd0,
		OP_LOSS = 2'd1,
		OP_LOAD = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SS_MUL,
		ST_SS_SUB,
		ST_SS_DIV,
		ST_CA_DIV1,
		ST_CA_BUMP,
		ST_CA_ACC,
		ST_CA_DIV2,
		ST_CA_MUL,
		ST_FINISH
	} state_t;

endpackage

/* sv/trw_if.sv */
// Valid/ready channel interfaces for event items and result items.
// Depends on trw_pkg for the field widths.
interface trw_req_if;
	import trw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_BITS-1:0]    operation;
	logic [ACKED_BITS-1:0] segments_acked;
	logic [LOAD_BITS-1:0]  load_window;
	logic [LOAD_BITS-1:0]  load_threshold;

	modport source(output valid, operation, segments_acked, load_window, load_threshold,
		input ready);
	modport sink(input valid, operation, segments_acked, load_window, load_threshold,
		output ready);
endinterface

interface trw_rsp_if;
	import trw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OUT_BITS-1:0]   window_bytes;
	logic [OUT_BITS-1:0]   threshold_bytes;
	logic                  was_slow_start;
	logic [ACKED_BITS-1:0] leftover_acked;

	modport source(output valid, window_bytes, threshold_bytes, was_slow_start,
		leftover_acked, input ready);
	modport sink(input valid, window_bytes, threshold_bytes, was_slow_start,
		leftover_acked, output ready);
endinterface

/* sv/trw_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on trw_pkg (imported for house consistency; widths come from W).
module trw_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	import trw_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift one dividend bit into the partial remainder, keep it if the divisor fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ~trial[W]};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* sv/trw_mul.sv */
// Shift-add multiplier: W-bit operand times segment size, one multiplier bit
// per cycle, MSB first. Depends on trw_pkg for SEG_BITS.
module trw_mul #(
	parameter int W = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [W-1:0]                  a,
	input  logic [trw_pkg::SEG_BITS-1:0]  b,
	output logic                          done,
	output logic [W+trw_pkg::SEG_BITS-1:0] prod
);
	import trw_pkg::*;

	localparam int PW = W + SEG_BITS;
	localparam int CW = $clog2(SEG_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [W-1:0]        a_q;
	logic [SEG_BITS-1:0] b_q;
	logic [PW-1:0]       acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SEG_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (b_q[SEG_BITS-1] ? PW'(a_q) : '0);
			b_q   <= {b_q[SEG_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* sv/tcp_reno_window_update.sv */
// Channel   Dir   Handshake     Payload
// req       in    valid/ready   operation, segments_acked, load_window, load_threshold
// rsp       out   valid/ready   window_bytes, threshold_bytes, was_slow_start, leftover_acked
// cfg       in    cfg_wr_en     cfg_wr_data = segment_size
//
// Loss, load and unused codes go from accept straight to finish. A nonzero slow-start ack runs
// the multiplier, a subtract step and the divider; a congestion-avoidance ack runs the divider,
// a bump and an accumulate step, then a second division and the multiplier if credit >= window.
// Reset is asynchronous and immediate; no clearing pass. The result waits in an output
// register, so the next item is taken while it is stalled; a finished item holds only when
// the previous result is still not taken.
// Depends on trw_pkg, trw_if, trw_div and trw_mul.
module tcp_reno_window_update #(
	parameter int WINDOW_BITS = trw_pkg::WINDOW_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	trw_req_if.sink                      req,
	trw_rsp_if.source                    rsp,
	input  logic                         cfg_wr_en,
	input  logic [trw_pkg::SEG_BITS-1:0] cfg_wr_data
);
	import trw_pkg::*;

	localparam int WB = WINDOW_BITS;
	localparam int DW = (WB > CNT_BITS) ? WB : CNT_BITS;
	localparam int PW = DW + SEG_BITS + 1;
	localparam int LW = DW + 1;
	localparam logic [WB-1:0] WIN_MAX = '1;

	state_t state_q, state_d;

	logic [WB-1:0]         window_q;
	logic [WB-1:0]         thresh_q;
	logic [CNT_BITS-1:0]   ack_q;
	logic [SEG_BITS-1:0]   seg_q;
	logic [WB-1:0]         old_q;
	logic [WB-1:0]         w_q;
	logic [ACKED_BITS-1:0] acked_q;
	logic                  slow_q;
	logic [ACKED_BITS-1:0] left_q;

	logic                  rsp_valid_q;
	logic [OUT_BITS-1:0]   rsp_win_q;
	logic [OUT_BITS-1:0]   rsp_thr_q;
	logic                  rsp_slow_q;
	logic [ACKED_BITS-1:0] rsp_left_q;

	op_t                   op_in;
	logic                  req_ready;
	logic                  accept;
	logic                  out_free;
	logic                  slow_now;
	logic [SEG_BITS-1:0]   seg_eff;

	logic                  div_start;
	logic [DW-1:0]         div_dividend;
	logic [DW-1:0]         div_divisor;
	logic                  div_done;
	logic [DW-1:0]         div_quot;
	logic [DW-1:0]         div_rem;

	logic                  mul_start;
	logic [DW-1:0]         mul_a;
	logic                  mul_done;
	logic [DW+SEG_BITS-1:0] mul_prod;

	logic [PW-1:0]         prod_sum;
	logic [WB-1:0]         win_prod;
	logic [WB-1:0]         ss_new;
	logic [WB:0]           bump_sum;
	logic [WB-1:0]         win_bump;
	logic [CNT_BITS:0]     ack_sum;
	logic [CNT_BITS-1:0]   ack_new;
	logic                  ack_ge_w_bump;
	logic                  ack_ge_w;
	logic [WB-1:0]         quot_w;
	logic [WB-1:0]         w_next;
	logic [SEG_BITS:0]     two_seg;
	logic [LW-1:0]         loss_cand;
	logic [WB-1:0]         thr_loss;
	logic [DW-1:0]         lw_ext;
	logic [DW-1:0]         lt_ext;
	logic [WB-1:0]         load_win;
	logic [WB-1:0]         load_thr;
	logic [DW-1:0]         win_ext;
	logic [DW-1:0]         thr_ext;

	assign op_in     = op_t'(req.operation);
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign slow_now  = window_q < thresh_q;
	assign seg_eff   = (seg_q == '0) ? SEG_BITS'(1) : seg_q;

	// window arithmetic, all sums saturating
	always_comb begin
		prod_sum      = PW'(window_q) + PW'(mul_prod);
		win_prod      = (prod_sum > PW'(WIN_MAX)) ? WIN_MAX : prod_sum[WB-1:0];
		ss_new        = (win_prod < thresh_q) ? win_prod : thresh_q;
		bump_sum      = {1'b0, window_q} + (WB+1)'(seg_eff);
		win_bump      = bump_sum[WB] ? WIN_MAX : bump_sum[WB-1:0];
		ack_sum       = {1'b0, ack_q} + (CNT_BITS+1)'(acked_q);
		ack_new       = ack_sum[CNT_BITS] ? '1 : ack_sum[CNT_BITS-1:0];
		ack_ge_w_bump = DW'(ack_q) >= DW'(w_q);
		ack_ge_w      = DW'(ack_new) >= DW'(w_q);
		quot_w        = div_quot[WB-1:0];
		w_next        = (quot_w == '0) ? WB'(1) : quot_w;
		two_seg       = {seg_eff, 1'b0};
		loss_cand     = (LW'(two_seg) > LW'(window_q >> 1)) ? LW'(two_seg)
			: LW'(window_q >> 1);
		thr_loss      = (loss_cand > LW'(WIN_MAX)) ? WIN_MAX : loss_cand[WB-1:0];
		lw_ext        = DW'(req.load_window);
		lt_ext        = DW'(req.load_threshold);
		load_win      = (lw_ext > DW'(WIN_MAX)) ? WIN_MAX : lw_ext[WB-1:0];
		load_thr      = (lt_ext > DW'(WIN_MAX)) ? WIN_MAX : lt_ext[WB-1:0];
		win_ext       = DW'(window_q);
		thr_ext       = DW'(thresh_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_in == OP_ACK) begin
						if (!slow_now) begin
							state_d = ST_CA_DIV1;
						end else if (req.segments_acked != '0) begin
							state_d = ST_SS_MUL;
						end else begin
							state_d = ST_FINISH;
						end
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SS_MUL:  if (mul_done) state_d = ST_SS_SUB;
			ST_SS_SUB:  state_d = ST_SS_DIV;
			ST_SS_DIV:  if (div_done) state_d = ST_FINISH;
			ST_CA_DIV1: if (div_done) state_d = ST_CA_BUMP;
			ST_CA_BUMP: state_d = ST_CA_ACC;
			ST_CA_ACC:  state_d = ack_ge_w ? ST_CA_DIV2 : ST_FINISH;
			ST_CA_DIV2: if (div_done) state_d = ST_CA_MUL;
			ST_CA_MUL:  if (mul_done) state_d = ST_FINISH;
			ST_FINISH:  if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit starts and operand selection
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DW'(window_q);
		div_divisor  = DW'(seg_eff);
		mul_start    = 1'b0;
		mul_a        = DW'(req.segments_acked);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op_in == OP_ACK) begin
					mul_start = slow_now && (req.segments_acked != '0);
					div_start = !slow_now;
				end
			end
			ST_SS_SUB: begin
				div_start    = 1'b1;
				div_dividend = DW'(window_q - old_q);
			end
			ST_CA_ACC: begin
				div_start    = ack_ge_w;
				div_dividend = DW'(ack_new);
				div_divisor  = DW'(w_q);
			end
			ST_CA_DIV2: begin
				mul_start = div_done;
				mul_a     = div_quot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window, threshold, ack counter and segment size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WB'(WINDOW_RESET);
			thresh_q <= WIN_MAX;
			ack_q    <= '0;
			seg_q    <= SEG_RESET;
		end else begin
			if (cfg_wr_en) begin
				seg_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op_in)
							OP_LOSS: thresh_q <= thr_loss;
							OP_LOAD: begin
								window_q <= load_win;
								thresh_q <= load_thr;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SS_MUL: if (mul_done) window_q <= ss_new;
				ST_CA_BUMP: begin
					// a full window of credit left from earlier acks: add one segment
					if (ack_ge_w_bump) begin
						ack_q    <= '0;
						window_q <= win_bump;
					end
				end
				ST_CA_ACC:  ack_q <= ack_new;
				ST_CA_DIV2: if (div_done) ack_q <= div_rem[CNT_BITS-1:0];
				ST_CA_MUL:  if (mul_done) window_q <= win_prod;
				default: begin
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					acked_q <= req.segments_acked;
					old_q   <= window_q;
					slow_q  <= (op_in == OP_ACK) && slow_now;
					left_q  <= '0;
				end
			end
			ST_SS_DIV:  if (div_done) left_q <= acked_q - div_quot[ACKED_BITS-1:0];
			ST_CA_DIV1: if (div_done) w_q <= w_next;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// load the result register once the previous item has left
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			rsp_win_q  <= win_ext[OUT_BITS-1:0];
			rsp_thr_q  <= thr_ext[OUT_BITS-1:0];
			rsp_slow_q <= slow_q;
			rsp_left_q <= left_q;
		end
	end

	assign req.ready           = req_ready;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.window_bytes    = rsp_win_q;
	assign rsp.threshold_bytes = rsp_thr_q;
	assign rsp.was_slow_start  = rsp_slow_q;
	assign rsp.leftover_acked  = rsp_left_q;

	trw_div #(
		.W(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	trw_mul #(
		.W(DW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (seg_eff),
		.done   (mul_done),
		.prod   (mul_prod)
	);

endmodule
